@@ design/led_matrix_remap_scan_unit_defines.svh @@
// assertion macros shared by the led matrix remap and scan design
// no dependencies; files that check their own logic include this header
`ifndef LED_MATRIX_REMAP_SCAN_UNIT_DEFINES_SVH
`define LED_MATRIX_REMAP_SCAN_UNIT_DEFINES_SVH

// checked on every clock edge outside reset
`define LMRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every clock edge, reset included
`define LMRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/lmrs_pkg.sv @@
// types, constants and helpers for the led matrix remap and scan design
// no dependencies
package lmrs_pkg;

    localparam int IMAGE_ROWS  = 15;
    localparam int IMAGE_COLS  = 15;
    localparam int LED_SIZE    = 8;
    localparam int TABLE_DEPTH = IMAGE_ROWS * IMAGE_COLS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COORD_W     = 3;
    localparam int ENTRY_W     = 2 * COORD_W;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_FRAME = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [3:0]        src_row;
        logic [3:0]        src_col;
        logic signed [3:0] led_x;
        logic signed [3:0] led_y;
        logic [7:0]        pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] line_index;
        logic [7:0] select_byte;
        logic [7:0] row_byte;
        logic       last_line;
    } out_item_t;

    // result of a table lookup, registered from the pixel transfer
    typedef struct packed {
        logic               set;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } lookup_t;

    function automatic logic in_range(input logic [3:0] row, input logic [3:0] col);
        return (int'(row) < IMAGE_ROWS) && (int'(col) < IMAGE_COLS);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_of(input logic [3:0] row,
                                                  input logic [3:0] col);
        return ADDR_W'(int'(row) * IMAGE_COLS + int'(col));
    endfunction

endpackage

@@ design/lmrs_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module lmrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/lmrs_table.sv @@
// translation table: per-entry valid flops plus coordinate ram
// depends on lmrs_pkg, lmrs_ram and the shared assertion header
`include "led_matrix_remap_scan_unit_defines.svh"

module lmrs_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic              rd_en,
    input  lmrs_pkg::in_item_t item,
    output lmrs_pkg::lookup_t lookup
);

    logic                        valid_reg [lmrs_pkg::TABLE_DEPTH];
    logic                        set_reg;
    logic                        hit_range;
    logic                        entry_ok;
    logic [lmrs_pkg::ADDR_W-1:0] slot;
    logic [lmrs_pkg::ENTRY_W-1:0] rd_entry;

    assign hit_range = lmrs_pkg::in_range(item.src_row, item.src_col);
    assign slot      = lmrs_pkg::slot_of(item.src_row, item.src_col);
    // negative coordinates read as large unsigned patterns, so one compare covers both
    assign entry_ok  = (int'($unsigned(item.led_x)) < lmrs_pkg::LED_SIZE)
                    && (int'($unsigned(item.led_y)) < lmrs_pkg::LED_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lmrs_pkg::TABLE_DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
            set_reg <= 1'b0;
        end else begin
            if (wr_en && hit_range) begin
                valid_reg[slot] <= entry_ok;
            end
            set_reg <= rd_en && hit_range && valid_reg[slot] && (item.pixel_value != 8'd0);
        end
    end

    lmrs_ram #(
        .WIDTH(lmrs_pkg::ENTRY_W),
        .DEPTH(lmrs_pkg::TABLE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en && hit_range && entry_ok),
        .wr_addr (slot),
        .wr_data ({item.led_x[lmrs_pkg::COORD_W-1:0], item.led_y[lmrs_pkg::COORD_W-1:0]}),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_entry)
    );

    assign lookup.set = set_reg;
    assign lookup.x   = rd_entry[lmrs_pkg::ENTRY_W-1:lmrs_pkg::COORD_W];
    assign lookup.y   = rd_entry[lmrs_pkg::COORD_W-1:0];

    `LMRS_ASSERT(a_set_follows_read, set_reg |-> $past(rd_en), "bit set without a pixel read")

endmodule

@@ design/lmrs_scan.sv @@
// row accumulator and line scan-out shift register with output register
// depends on lmrs_pkg and the shared assertion header
`include "led_matrix_remap_scan_unit_defines.svh"

module lmrs_scan (
    input  logic                aclk,
    input  logic                aresetn,
    input  lmrs_pkg::lookup_t   lookup,
    input  logic                start,
    output logic                busy,
    output logic                m_valid,
    input  logic                m_ready,
    output lmrs_pkg::out_item_t m_data
);

    logic [7:0]          acc_reg [lmrs_pkg::LED_SIZE];
    logic [7:0]          acc_next [lmrs_pkg::LED_SIZE];
    logic                active_reg;
    logic [2:0]          line_reg;
    logic                m_valid_reg;
    lmrs_pkg::out_item_t m_data_reg;
    logic                load;
    logic                last;

    assign load = active_reg && (!m_valid_reg || m_ready);
    assign last = (line_reg == 3'(lmrs_pkg::LED_SIZE - 1));

    // rows shift towards row 0 during the scan, zeros fill in behind
    always_comb begin
        for (int i = 0; i < lmrs_pkg::LED_SIZE; i++) begin
            acc_next[i] = acc_reg[i];
            if (load) begin
                acc_next[i] = (i == lmrs_pkg::LED_SIZE - 1) ? 8'd0 : acc_reg[(i + 1) % lmrs_pkg::LED_SIZE];
            end else if (lookup.set && (int'(lookup.y) == i)) begin
                acc_next[i] = acc_reg[i] | (8'd1 << lookup.x);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lmrs_pkg::LED_SIZE; i++) begin
                acc_reg[i] <= 8'd0;
            end
            active_reg  <= 1'b0;
            line_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            if (start) begin
                active_reg <= 1'b1;
                line_reg   <= 3'd0;
            end else if (load) begin
                active_reg <= !last;
                line_reg   <= last ? 3'd0 : line_reg + 3'd1;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.line_index  <= line_reg;
            m_data_reg.select_byte <= ~(8'd1 << line_reg);
            m_data_reg.row_byte    <= acc_reg[0];
            m_data_reg.last_line   <= last;
        end
    end

    assign busy    = active_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `LMRS_ASSERT_ALWAYS(a_idle_line_zero, (aresetn && !active_reg) |=> (active_reg || line_reg == 3'd0), "line counter left nonzero when idle")
    `LMRS_ASSERT(a_no_restart, start |-> !active_reg, "frame end taken during a scan")
    `LMRS_ASSERT(a_scan_ends, (load && last) |=> (!active_reg && m_valid_reg && m_data_reg.last_line), "scan did not end on the last line")

endmodule

@@ design/led_matrix_remap_scan_unit.sv @@
// top level of the led matrix remap and scan design
// depends on lmrs_pkg, lmrs_table and lmrs_scan
//
// Remaps a 15x15 source image onto an 8x8 led matrix. Table-write transfers
// load one translation entry, pixel transfers light one led bit, and a
// frame-end transfer emits eight line results (line index, inverted one-hot
// select byte, row byte, last-line flag) before clearing the accumulator.
// Timing: table writes and pixels never hold the input off; a pixel's bit
// reaches the accumulator after the registered read of the coordinate ram
// and the registered set flag. A frame end holds the input off while the
// accumulator shifts out one row a cycle through the output register
// unless m_ready stalls; the next transfer is taken as soon as the last
// line sits in the output register. Entry valid flags live in 225 flops
// cleared by reset, so no clearing pass is needed.
module led_matrix_remap_scan_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lmrs_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lmrs_pkg::out_item_t m_data
);

    logic              accept;
    logic              busy;
    lmrs_pkg::lookup_t lookup;

    // input is held off only while a frame is being scanned out
    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    // unknown action code falls through all three decodes and is dropped
    lmrs_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && (s_data.action == lmrs_pkg::ACT_WRITE)),
        .rd_en   (accept && (s_data.action == lmrs_pkg::ACT_PIXEL)),
        .item    (s_data),
        .lookup  (lookup)
    );

    // accumulator plus scan-out; output register decouples the result side
    lmrs_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .lookup  (lookup),
        .start   (accept && (s_data.action == lmrs_pkg::ACT_FRAME)),
        .busy    (busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ test/tb_led_matrix_remap_scan_unit.sv @@
// testbench for led_matrix_remap_scan_unit: remap table writes, pixels and frame scan-out
// depends on lmrs_pkg and the led_matrix_remap_scan_unit design files
`timescale 1ns / 100ps

module tb_led_matrix_remap_scan_unit;
    import lmrs_pkg::*;

    // minimum length of the whole stimulus in transfers, directed ones included
    localparam int RANDOM_ITEMS = 170;
    // cycles without any transfer before the run is called hung
    localparam int IDLE_LIMIT   = 2000;
    // settling time after the last line
    localparam int DRAIN_CYCLES = 32;

    // one translation entry as the block keeps it: mapped flag and led coordinate
    typedef struct packed {
        logic       mapped;
        logic [2:0] x;
        logic [2:0] y;
    } coord_entry_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // stimulus waiting to go out, and scan lines still owed by the block
    in_item_t  pending[$];
    out_item_t expected_lines[$];

    // shadow copy of the block's state
    coord_entry_t coord_map[TABLE_DEPTH];
    logic [7:0]   line_acc[LED_SIZE];

    int total_items    = 0;
    int accepted_items = 0;
    int mismatch_count = 0;
    int lines_checked  = 0;
    int frames_seen    = 0;
    int entries_set    = 0;
    int pixels_lit     = 0;
    int idle_cycles    = 0;

    led_matrix_remap_scan_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // --------------------------------------------------------------------
    // prediction: table update, bit set, eight-line scan-out or nothing per transfer
    // --------------------------------------------------------------------
    function automatic void remap_and_scan(input in_item_t it);
        int         slot;
        logic [3:0] ux;
        logic [3:0] uy;
        out_item_t  line_res;
        coord_entry_t e;
        ux = it.led_x;
        uy = it.led_y;
        // source positions outside the image are dropped for writes and pixels
        slot = int'(it.src_row) * IMAGE_COLS + int'(it.src_col);
        case (it.action)
            ACT_WRITE: begin
                if (int'(it.src_row) < IMAGE_ROWS && int'(it.src_col) < IMAGE_COLS) begin
                    // any negative pattern, or one past the matrix, marks the pixel unused
                    if (int'(ux) < LED_SIZE && int'(uy) < LED_SIZE) begin
                        coord_map[slot] = '{1'b1, ux[2:0], uy[2:0]};
                        entries_set++;
                    end else begin
                        coord_map[slot] = '0;
                    end
                end
            end
            ACT_PIXEL: begin
                if (int'(it.src_row) < IMAGE_ROWS && int'(it.src_col) < IMAGE_COLS) begin
                    e = coord_map[slot];
                    // unused entries and dark pixels leave the accumulator alone
                    if (e.mapped && it.pixel_value != 8'd0) begin
                        line_acc[e.y][e.x] = 1'b1;
                        pixels_lit++;
                    end
                end
            end
            ACT_FRAME: begin
                for (int ln = 0; ln < LED_SIZE; ln++) begin
                    line_res.line_index  = 3'(ln);
                    line_res.select_byte = ~(8'd1 << ln);
                    line_res.row_byte    = line_acc[ln];
                    line_res.last_line   = (ln == LED_SIZE - 1);
                    expected_lines.push_back(line_res);
                    line_acc[ln] = 8'd0;
                end
                frames_seen++;
            end
            default: begin
                // action three is ignored by the block
            end
        endcase
    endfunction

    // --------------------------------------------------------------------
    // stimulus helpers
    // --------------------------------------------------------------------
    function automatic in_item_t make_item(input logic [1:0] act, input logic [3:0] row,
                                           input logic [3:0] col, input logic [3:0] lx,
                                           input logic [3:0] ly, input logic [7:0] pix);
        in_item_t it;
        it.action      = act;
        it.src_row     = row;
        it.src_col     = col;
        it.led_x       = lx;
        it.led_y       = ly;
        it.pixel_value = pix;
        return it;
    endfunction

    // mostly inside the image, now and then the one-past position
    function automatic logic [3:0] pick_coord();
        return ($urandom_range(0, 15) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
    endfunction

    // mostly a real led coordinate, sometimes a negative (unused) pattern
    function automatic logic [3:0] pick_led();
        return ($urandom_range(0, 6) == 0) ? 4'($urandom_range(8, 15))
                                           : 4'($urandom_range(0, 7));
    endfunction

    task automatic queue_directed();
        // empty frame straight out of reset
        pending.push_back(make_item(ACT_FRAME, 4'd0, 4'd0, 4'd0, 4'd0, 8'd0));
        // image corners to matrix corners
        pending.push_back(make_item(ACT_WRITE, 4'd0, 4'd0, 4'd7, 4'd0, 8'd0));
        pending.push_back(make_item(ACT_WRITE, 4'd14, 4'd14, 4'd0, 4'd7, 8'hFF));
        // unused marks: -1 column, most negative row
        pending.push_back(make_item(ACT_WRITE, 4'd0, 4'd14, 4'hF, 4'd3, 8'd0));
        pending.push_back(make_item(ACT_WRITE, 4'd14, 4'd0, 4'd2, 4'h8, 8'd0));
        // writes outside the image, row then column
        pending.push_back(make_item(ACT_WRITE, 4'd15, 4'd3, 4'd1, 4'd1, 8'd0));
        pending.push_back(make_item(ACT_WRITE, 4'd3, 4'd15, 4'd1, 4'd1, 8'd0));
        pending.push_back(make_item(ACT_WRITE, 4'd5, 4'd5, 4'd3, 4'd4, 8'd0));
        pending.push_back(make_item(ACT_PIXEL, 4'd0, 4'd0, 4'd0, 4'd0, 8'hFF));
        pending.push_back(make_item(ACT_PIXEL, 4'd14, 4'd14, 4'hF, 4'hF, 8'd1));
        // pixels on unused entries
        pending.push_back(make_item(ACT_PIXEL, 4'd0, 4'd14, 4'd0, 4'd0, 8'h80));
        pending.push_back(make_item(ACT_PIXEL, 4'd14, 4'd0, 4'd0, 4'd0, 8'h07));
        // dark pixel on a mapped entry
        pending.push_back(make_item(ACT_PIXEL, 4'd5, 4'd5, 4'd0, 4'd0, 8'd0));
        // pixels outside the image
        pending.push_back(make_item(ACT_PIXEL, 4'd15, 4'd3, 4'd0, 4'd0, 8'h09));
        pending.push_back(make_item(ACT_PIXEL, 4'd3, 4'd15, 4'd0, 4'd0, 8'h09));
        // entry never written since reset
        pending.push_back(make_item(ACT_PIXEL, 4'd7, 4'd7, 4'd0, 4'd0, 8'hC8));
        pending.push_back(make_item(ACT_NONE, 4'hF, 4'hF, 4'hF, 4'hF, 8'hFF));
        pending.push_back(make_item(ACT_FRAME, 4'hF, 4'hF, 4'hF, 4'hF, 8'hFF));
        // overwrite a mapped entry as unused, then light it
        pending.push_back(make_item(ACT_WRITE, 4'd5, 4'd5, 4'hF, 4'hF, 8'd0));
        pending.push_back(make_item(ACT_PIXEL, 4'd5, 4'd5, 4'd0, 4'd0, 8'h55));
        pending.push_back(make_item(ACT_WRITE, 4'd15, 4'd15, 4'd7, 4'd7, 8'hFF));
        pending.push_back(make_item(ACT_FRAME, 4'd0, 4'd0, 4'd0, 4'd0, 8'd0));
        pending.push_back(make_item(ACT_FRAME, 4'd0, 4'd0, 4'd0, 4'd0, 8'd0));
    endtask

    // random frames: a few table writes, pixels mostly on written slots, now and then an ignored action, frame end
    task automatic queue_random_frames();
        int         n;
        logic [3:0] r;
        logic [3:0] c;
        logic [7:0] pv;
        logic [7:0] spot;
        logic [7:0] written[$];
        while (pending.size() < RANDOM_ITEMS) begin
            n = $urandom_range(0, 6);
            repeat (n) begin
                r = pick_coord();
                c = pick_coord();
                pending.push_back(make_item(ACT_WRITE, r, c, pick_led(), pick_led(),
                                            8'($urandom)));
                if (int'(r) < IMAGE_ROWS && int'(c) < IMAGE_COLS) begin
                    written.push_back({r, c});
                end
            end
            if (written.size() > 24) written.delete(0);
            n = $urandom_range(2, 12);
            repeat (n) begin
                if (written.size() > 0 && $urandom_range(0, 4) != 0) begin
                    spot = written[$urandom_range(0, written.size() - 1)];
                    r    = spot[7:4];
                    c    = spot[3:0];
                end else begin
                    r = pick_coord();
                    c = pick_coord();
                end
                pv = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                pending.push_back(make_item(ACT_PIXEL, r, c, 4'($urandom), 4'($urandom), pv));
            end
            if ($urandom_range(0, 9) == 0) begin
                pending.push_back(make_item(ACT_NONE, 4'($urandom), 4'($urandom),
                                            4'($urandom), 4'($urandom), 8'($urandom)));
            end
            pending.push_back(make_item(ACT_FRAME, 4'($urandom), 4'($urandom),
                                        4'($urandom), 4'($urandom), 8'($urandom)));
        end
    endtask

    // --------------------------------------------------------------------
    // driver: bursts of transfers with random gaps in between
    // --------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                remap_and_scan(s_data);
                accepted_items++;
            end
            // channel is free once the current transfer has gone or none is up
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    s_data  <= pending.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        // a third of the bursts run back to back with no gap
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // receiver: ready follows a 16-bit pattern picked afresh each period
    // --------------------------------------------------------------------
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_phase   = 0;

    always @(posedge aclk) begin
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = 16'hFFFF;
                1:       stall_pattern = 16'($urandom);
                2:       stall_pattern = 16'h000F;
                default: stall_pattern = 16'hAAAA;
            endcase
        end
        m_ready     <= stall_pattern[stall_phase];
        stall_phase = (stall_phase + 1) % 16;
    end

    // --------------------------------------------------------------------
    // monitor: every line transfer against the oldest predicted line
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lines.size() == 0) begin
                $error("unexpected line transfer: line_index %0d row_byte %02h",
                       m_data.line_index, m_data.row_byte);
                mismatch_count++;
            end else begin
                want = expected_lines.pop_front();
                lines_checked++;
                if (m_data.line_index !== want.line_index) begin
                    $error("line_index: expected %0d, got %0d",
                           want.line_index, m_data.line_index);
                    mismatch_count++;
                end
                if (m_data.select_byte !== want.select_byte) begin
                    $error("select_byte: expected %02h, got %02h",
                           want.select_byte, m_data.select_byte);
                    mismatch_count++;
                end
                if (m_data.row_byte !== want.row_byte) begin
                    $error("row_byte: expected %02h, got %02h",
                           want.row_byte, m_data.row_byte);
                    mismatch_count++;
                end
                if (m_data.last_line !== want.last_line) begin
                    $error("last_line: expected %0d, got %0d",
                           want.last_line, m_data.last_line);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // --------------------------------------------------------------------
    // sequencing: reset, stimulus, drain, verdict
    // --------------------------------------------------------------------
    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) coord_map[i] = '0;
        for (int i = 0; i < LED_SIZE; i++) line_acc[i] = 8'd0;
        queue_directed();
        queue_random_frames();
        total_items = pending.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_items < total_items || expected_lines.size() != 0) @(posedge aclk);
        // catch any stray line after the last expected one
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d transfers (%0d table entries mapped, %0d pixels lit)",
                 accepted_items, entries_set, pixels_lit);
        $display("checked %0d scan lines over %0d frames", lines_checked, frames_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
